// File: rtl/core/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg: shared types and constants of the HTTP request line parser
// Request and response structs, queue entry layout, parse phases, status
// codes and the constant match strings.
// ----------------------------------------------------------------------------
package hrlp_pkg;

   // Request payload: one raw byte of the incoming request
   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_request;
      logic       end_of_data;
   } req_type;

   // Response payload: one result
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       method;
      logic       version;
      logic       last;
   } rsp_type;

   // Work handed from the front part to the back part for one accepted byte
   typedef struct packed {
      logic       byte_valid;
      logic       byte_param;   // 0 URI byte, 1 parameter byte
      logic [7:0] data_byte;
      logic       status_valid;
      logic [2:0] status;
      logic       method;
      logic       version;
   } queue_entry_type;

   // Queue occupancy flags seen by both neighbors
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_SKIP1,
      PH_URI,
      PH_PARAM,
      PH_SKIP2,
      PH_VERSION,
      PH_DONE
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_URI    = 2'd0;
   localparam logic [1:0] KIND_PARAM  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes, plus two internal verdict values
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_MORE        = 3'd1;
   localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
   localparam logic [2:0] ST_TOO_LONG    = 3'd3;
   localparam logic [2:0] ST_BAD_VERSION = 3'd4;
   localparam logic [2:0] VD_PENDING     = 3'd5;
   localparam logic [2:0] VD_REPORTED    = 3'd6;

   // Register indexes
   localparam logic CSR_URI_LIMIT   = 1'b0;
   localparam logic CSR_PARAM_LIMIT = 1'b1;

   localparam logic [7:0]  URI_LIMIT_RESET   = 8'd255;
   localparam logic [10:0] PARAM_LIMIT_RESET = 11'd1024;

   // Characters
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_P     = 8'h50;

   localparam logic METHOD_GET = 1'b0;
   localparam logic METHOD_PUT = 1'b1;

   // Character idx of "GET" (sel 0) or "PUT" (sel 1)
   function automatic logic [7:0] method_char(input logic sel, input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = sel ? CH_P : CH_G;
         2'd1:    ch = sel ? 8'h55 : 8'h45;   // U / E
         2'd2:    ch = 8'h54;                 // T
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Character idx of "HTTP/1.0" (minor 0) or "HTTP/1.1" (minor 1)
   function automatic logic [7:0] version_char(input logic [2:0] idx, input logic minor);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h48;   // H
         3'd1:    ch = 8'h54;   // T
         3'd2:    ch = 8'h54;   // T
         3'd3:    ch = 8'h50;   // P
         3'd4:    ch = 8'h2F;   // /
         3'd5:    ch = 8'h31;   // 1
         3'd6:    ch = 8'h2E;   // .
         default: ch = minor ? 8'h31 : 8'h30;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/core/hrlp_front.sv
// ----------------------------------------------------------------------------
// hrlp_front: byte classifier of the request line parser
// Accepts request bytes, runs the parse state machine and the blank-line
// watch, and pushes the results each byte causes into the queue.
// ----------------------------------------------------------------------------
module hrlp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [10:0]                  csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  hrlp_pkg::req_type            req_payload,
   input  hrlp_pkg::queue_status_type   q_status,
   output logic                         q_push,
   output hrlp_pkg::queue_entry_type    q_push_entry
);
   import hrlp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [10:0] count_ff, count_in;
   logic [2:0]  match_ff, match_in;
   logic [1:0]  vcand_ff, vcand_in;
   logic [23:0] recent_ff, recent_in;
   logic        term_ff, term_in;
   logic [2:0]  verdict_ff, verdict_in;
   logic        method_ff, method_in;
   logic [7:0]  uri_limit_ff;
   logic [10:0] param_limit_ff;

   logic        accept;
   logic        used;
   logic        term_hit;
   logic [7:0]  b;
   queue_entry_type entry;

   assign b         = req_payload.data_byte;
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      match_in   = match_ff;
      vcand_in   = vcand_ff;
      recent_in  = recent_ff;
      term_in    = term_ff;
      verdict_in = verdict_ff;
      method_in  = method_ff;
      used       = 1'b0;
      entry      = '0;

      if (req_payload.new_request) begin
         phase_in   = PH_METHOD;
         count_in   = '0;
         match_in   = '0;
         vcand_in   = 2'b11;
         recent_in  = '0;
         term_in    = 1'b0;
         verdict_in = VD_PENDING;
         method_in  = METHOD_GET;
      end

      // blank line watch: LF LF or CR LF CR LF
      term_hit = (b == CH_LF) &&
                 ((recent_in[7:0] == CH_LF) ||
                  (recent_in[7:0] == CH_CR && recent_in[15:8] == CH_LF &&
                   recent_in[23:16] == CH_CR));
      if (term_hit) begin
         term_in = 1'b1;
      end
      recent_in = {recent_in[15:0], b};

      if (verdict_in == VD_PENDING) begin
         if (phase_in == PH_METHOD) begin
            used = 1'b1;
            if (match_in == 3'd0) begin
               if (b == CH_G) begin
                  method_in = METHOD_GET;
               end else if (b == CH_P) begin
                  method_in = METHOD_PUT;
               end else begin
                  verdict_in = ST_BAD_METHOD;
                  phase_in   = PH_DONE;
               end
            end else if (match_in > 3'd2 || b != method_char(method_in, match_in[1:0])) begin
               verdict_in = ST_BAD_METHOD;
               phase_in   = PH_DONE;
            end
            if (verdict_in == VD_PENDING) begin
               if (match_in == 3'd2) begin
                  match_in = '0;
                  phase_in = PH_SKIP1;
               end else begin
                  match_in = match_in + 3'd1;
               end
            end
         end
         if (!used && phase_in == PH_SKIP1) begin
            if (b == CH_SPACE) begin
               used = 1'b1;
            end else begin
               phase_in = PH_URI;
            end
         end
         if (!used && phase_in == PH_URI) begin
            used = 1'b1;
            if (b == CH_SPACE) begin
               phase_in = PH_SKIP2;
            end else if (b == CH_QMARK) begin
               phase_in = PH_PARAM;
               count_in = '0;
            end else if (count_in < {3'b000, uri_limit_ff}) begin
               entry.byte_valid = 1'b1;
               entry.byte_param = 1'b0;
               entry.data_byte  = b;
               count_in         = count_in + 11'd1;
            end else begin
               verdict_in = ST_TOO_LONG;
               phase_in   = PH_DONE;
            end
         end
         if (!used && phase_in == PH_PARAM) begin
            used = 1'b1;
            if (b == CH_SPACE) begin
               phase_in = PH_SKIP2;
            end else if (count_in < param_limit_ff) begin
               entry.byte_valid = 1'b1;
               entry.byte_param = 1'b1;
               entry.data_byte  = b;
               count_in         = count_in + 11'd1;
            end else begin
               verdict_in = ST_TOO_LONG;
               phase_in   = PH_DONE;
            end
         end
         if (!used && phase_in == PH_SKIP2) begin
            if (b == CH_SPACE) begin
               used = 1'b1;
            end else begin
               phase_in = PH_VERSION;
               match_in = '0;
               vcand_in = 2'b11;
            end
         end
         if (!used && phase_in == PH_VERSION) begin
            if (b != version_char(match_in, 1'b0)) begin
               vcand_in[0] = 1'b0;
            end
            if (b != version_char(match_in, 1'b1)) begin
               vcand_in[1] = 1'b0;
            end
            if (vcand_in == 2'b00) begin
               verdict_in = ST_BAD_VERSION;
               phase_in   = PH_DONE;
            end else if (match_in == 3'd7) begin
               match_in   = '0;
               verdict_in = ST_OK;
               phase_in   = PH_DONE;
            end else begin
               match_in = match_in + 3'd1;
            end
         end
      end

      if (req_payload.end_of_data && term_in && verdict_in == VD_PENDING) begin
         verdict_in = ST_BAD_VERSION;
         phase_in   = PH_DONE;
      end

      if (term_in && verdict_in <= ST_BAD_VERSION) begin
         entry.status_valid = 1'b1;
         entry.status       = verdict_in;
         entry.method       = (verdict_in == ST_OK) ? method_in : 1'b0;
         entry.version      = (verdict_in == ST_OK) ? vcand_in[1] : 1'b0;
         verdict_in         = VD_REPORTED;
      end else if (req_payload.end_of_data && verdict_in != VD_REPORTED) begin
         entry.status_valid = 1'b1;
         entry.status       = ST_MORE;
      end
   end

   assign q_push       = accept && (entry.byte_valid || entry.status_valid);
   assign q_push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_METHOD;
         count_ff   <= '0;
         match_ff   <= '0;
         vcand_ff   <= 2'b11;
         recent_ff  <= '0;
         term_ff    <= 1'b0;
         verdict_ff <= VD_PENDING;
         method_ff  <= METHOD_GET;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         match_ff   <= match_in;
         vcand_ff   <= vcand_in;
         recent_ff  <= recent_in;
         term_ff    <= term_in;
         verdict_ff <= verdict_in;
         method_ff  <= method_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uri_limit_ff   <= URI_LIMIT_RESET;
         param_limit_ff <= PARAM_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_URI_LIMIT:   uri_limit_ff   <= csr_data[7:0];
            CSR_PARAM_LIMIT: param_limit_ff <= csr_data;
            default:         ;
         endcase
      end
   end

endmodule

// File: rtl/core/hrlp_queue.sv
// ----------------------------------------------------------------------------
// hrlp_queue: work queue between front and back parts
// Small register FIFO of per-byte work entries.
// ----------------------------------------------------------------------------
module hrlp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  hrlp_pkg::queue_entry_type    push_entry,
   input  logic                         pop,
   output hrlp_pkg::queue_entry_type    head,
   output hrlp_pkg::queue_status_type   status
);
   import hrlp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/hrlp_back.sv
// ----------------------------------------------------------------------------
// hrlp_back: result emitter of the request line parser
// Drains queue entries into the response register, one result per cycle
// while the consumer is ready, byte result first and status report after it.
// ----------------------------------------------------------------------------
module hrlp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  hrlp_pkg::queue_entry_type    head,
   input  hrlp_pkg::queue_status_type   q_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output hrlp_pkg::rsp_type            rsp_payload
);
   import hrlp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    byte_sent_ff, byte_sent_in;
   logic    load;

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      byte_sent_in = byte_sent_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            rsp_in = '0;
            if (head.byte_valid && !byte_sent_ff) begin
               rsp_in.kind     = head.byte_param ? KIND_PARAM : KIND_URI;
               rsp_in.out_byte = head.data_byte;
               rsp_in.last     = !head.status_valid;
               pop             = !head.status_valid;
               byte_sent_in    = head.status_valid;
            end else begin
               rsp_in.kind    = KIND_STATUS;
               rsp_in.status  = head.status;
               rsp_in.method  = head.method;
               rsp_in.version = head.version;
               rsp_in.last    = 1'b1;
               pop            = 1'b1;
               byte_sent_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         byte_sent_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         byte_sent_ff <= byte_sent_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/core/http_request_line_parser_top.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_top: HTTP request line parser
// Byte-serial parser of GET/PUT request lines with URI and parameter output.
// ----------------------------------------------------------------------------
// The block takes one request byte per cycle: it is ready whenever its work
// queue (QUEUE_DEPTH entries) has room, so a stream of bytes is accepted back
// to back until the queue fills. Each byte is classified in the cycle it is
// accepted and yields zero, one or two results; the results leave through a
// single response register at one result per cycle while the consumer is
// ready, so a byte that produces both a URI or parameter byte and a status
// report sends them one after the other, and sustained throughput is set by
// that register and the consumer's ready. The method is matched on the first
// three bytes, URI bytes go out as kind URI until a space or '?', parameter
// bytes as kind parameter until a space, and the version is matched after
// the spaces that follow. A status report (kind status) goes out only once a
// blank line (LF LF or CR LF CR LF) has been seen; at end_of_data without it,
// need-more is reported and the parse state kept. Set new_request on the
// first byte of each request. The URI and parameter limits are written
// through the csr_ port (index 0 URI limit, index 1 parameter limit); the
// user must write them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module http_request_line_parser_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [10:0]         csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  hrlp_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hrlp_pkg::rsp_type   rsp_payload
);
   import hrlp_pkg::*;

   queue_status_type q_status;
   queue_entry_type  q_push_entry;
   queue_entry_type  q_head;
   logic             q_push;
   logic             q_pop;

   // Front: parse each accepted request and push its work
   hrlp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   // Queue: decouple parsing from result delivery
   hrlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // Back: emit results one per cycle through the response register while the consumer is ready
   hrlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_status    (q_status),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Queue cannot be full and empty at once
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");

   // Pending work with a free response register must show up next cycle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && !rsp_valid) |=> rsp_valid)
      else $error("queued work not delivered");

   // Method and version are zero unless the status is ok
   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == KIND_STATUS && rsp_payload.status != ST_OK)
         |-> (!rsp_payload.method && !rsp_payload.version))
      else $error("method or version set on a failing status");

   // A byte result is marked last only when its byte reports no status; status
   // reports are always marked last, which is what is checked here
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == KIND_STATUS) |-> rsp_payload.last)
      else $error("status report not marked last");

endmodule

// File: tb/tb_http_request_line_parser_top.sv
// ----------------------------------------------------------------------------
// tb_http_request_line_parser_top: testbench of the HTTP request line parser
// Feed request bytes through the valid/ready input, mirror the parse in a
// byte-level predictor and compare every result field by field. Cover the
// request forms, held verdicts, length limits and output backpressure, then
// run random requests under several limit settings.
// ----------------------------------------------------------------------------
module tb_http_request_line_parser_top;
   import hrlp_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   localparam logic [23:0] GET_TEXT = "GET";
   localparam logic [23:0] PUT_TEXT = "PUT";
   localparam logic [63:0] V10_TEXT = "HTTP/1.0";
   localparam logic [63:0] V11_TEXT = "HTTP/1.1";
   localparam int          RANDOM_BYTES = 150;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write;
   logic        csr_index;
   logic [10:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;

   // Parse state mirrored from the block
   phase_type   parse_phase;
   int          parse_count;
   int          match_pos;
   logic [1:0]  version_mask;
   logic [23:0] last_three;
   logic        blank_line_seen;
   logic [2:0]  pending_verdict;
   logic        matched_method;
   int          uri_limit_now;
   int          param_limit_now;

   // Results the block still owes, oldest first
   rsp_type     parser_outputs_due[$];

   int          error_count;
   int          bytes_sent;
   int          results_checked;
   int          limit_writes;
   int          status_seen[5];
   int          burst_left;
   bit          sender_gaps;
   int          rsp_hold_off;
   int          stall_mode;
   int          stall_tick;

   http_request_line_parser_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // Hard stop in case a handshake never completes
   initial begin
      #6000000;
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic void clear_parse_state();
      parse_phase     = PH_METHOD;
      parse_count     = 0;
      match_pos       = 0;
      version_mask    = 2'b11;
      last_three      = '0;
      blank_line_seen = 1'b0;
      pending_verdict = VD_PENDING;
      matched_method  = METHOD_GET;
   endfunction

   function automatic rsp_type make_result(logic [1:0] kind, logic [7:0] b,
                                           logic [2:0] st, logic meth, logic ver);
      rsp_type r;
      r.kind     = kind;
      r.out_byte = b;
      r.status   = st;
      r.method   = meth;
      r.version  = ver;
      r.last     = 1'b0;
      return r;
   endfunction

   // Advance the mirrored parse by one accepted request byte and queue its results
   function automatic void parse_request_byte(req_type r);
      logic [7:0]  b;
      logic [23:0] mtext;
      logic [1:0]  c;
      logic        ok;
      bit          used;
      rsp_type     outs[$];
      b    = r.data_byte;
      used = 0;
      if (r.new_request)
         clear_parse_state();

      // Watch the whole stream for LF LF or CR LF CR LF
      if (b == CH_LF && (last_three[7:0] == CH_LF ||
          (last_three[7:0] == CH_CR && last_three[15:8] == CH_LF &&
           last_three[23:16] == CH_CR)))
         blank_line_seen = 1'b1;
      last_three = {last_three[15:0], b};

      if (pending_verdict == VD_PENDING) begin
         if (parse_phase == PH_METHOD) begin
            used  = 1;
            mtext = matched_method ? PUT_TEXT : GET_TEXT;
            if (match_pos == 0) begin
               if (b == CH_G)
                  matched_method = METHOD_GET;
               else if (b == CH_P)
                  matched_method = METHOD_PUT;
               else
                  pending_verdict = ST_BAD_METHOD;
            end else if (match_pos > 2 || b != mtext[23 - 8*match_pos -: 8]) begin
               pending_verdict = ST_BAD_METHOD;
            end
            if (pending_verdict == VD_PENDING) begin
               match_pos++;
               if (match_pos >= 3) begin
                  match_pos   = 0;
                  parse_phase = PH_SKIP1;
               end
            end else begin
               parse_phase = PH_DONE;
            end
         end
         if (!used && parse_phase == PH_SKIP1) begin
            if (b == CH_SPACE)
               used = 1;
            else
               parse_phase = PH_URI;
         end
         if (!used && parse_phase == PH_URI) begin
            used = 1;
            if (b == CH_SPACE) begin
               parse_phase = PH_SKIP2;
            end else if (b == CH_QMARK) begin
               parse_phase = PH_PARAM;
               parse_count = 0;
            end else if (parse_count < uri_limit_now) begin
               outs.push_back(make_result(KIND_URI, b, ST_OK, 1'b0, 1'b0));
               parse_count++;
            end else begin
               pending_verdict = ST_TOO_LONG;
               parse_phase     = PH_DONE;
            end
         end
         if (!used && parse_phase == PH_PARAM) begin
            used = 1;
            if (b == CH_SPACE) begin
               parse_phase = PH_SKIP2;
            end else if (parse_count < param_limit_now) begin
               outs.push_back(make_result(KIND_PARAM, b, ST_OK, 1'b0, 1'b0));
               parse_count++;
            end else begin
               pending_verdict = ST_TOO_LONG;
               parse_phase     = PH_DONE;
            end
         end
         if (!used && parse_phase == PH_SKIP2) begin
            if (b == CH_SPACE) begin
               used = 1;
            end else begin
               parse_phase  = PH_VERSION;
               match_pos    = 0;
               version_mask = 2'b11;
            end
         end
         if (!used && parse_phase == PH_VERSION) begin
            c = version_mask;
            if (match_pos < 8) begin
               if (b != V10_TEXT[63 - 8*match_pos -: 8]) c[0] = 1'b0;
               if (b != V11_TEXT[63 - 8*match_pos -: 8]) c[1] = 1'b0;
            end else begin
               c = 2'b00;
            end
            version_mask = c;
            if (c == 2'b00) begin
               pending_verdict = ST_BAD_VERSION;
               parse_phase     = PH_DONE;
            end else begin
               match_pos++;
               if (match_pos >= 8) begin
                  pending_verdict = ST_OK;
                  parse_phase     = PH_DONE;
               end
            end
         end
      end

      // Data ran out after the blank line but before any verdict
      if (r.end_of_data && blank_line_seen && pending_verdict == VD_PENDING) begin
         pending_verdict = ST_BAD_VERSION;
         parse_phase     = PH_DONE;
      end

      if (blank_line_seen && pending_verdict <= ST_BAD_VERSION) begin
         ok = (pending_verdict == ST_OK);
         outs.push_back(make_result(KIND_STATUS, 8'h00, pending_verdict,
                                    ok ? matched_method : 1'b0,
                                    ok ? version_mask[1] : 1'b0));
         pending_verdict = VD_REPORTED;
      end else if (r.end_of_data && pending_verdict != VD_REPORTED) begin
         outs.push_back(make_result(KIND_STATUS, 8'h00, ST_MORE, 1'b0, 1'b0));
      end

      if (outs.size() > 0)
         outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i])
         parser_outputs_due.push_back(outs[i]);
   endfunction

   // -------------------------------------------------------------------------
   // Result checking: compare each accepted result with the oldest one owed
   // -------------------------------------------------------------------------
   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parser_outputs_due.size() == 0) begin
            $error("unexpected result: kind %0d byte %0d status %0d",
                   rsp_payload.kind, rsp_payload.out_byte, rsp_payload.status);
            error_count++;
         end else begin
            want = parser_outputs_due.pop_front();
            check_field("kind", want.kind, rsp_payload.kind);
            check_field("out_byte", want.out_byte, rsp_payload.out_byte);
            check_field("status", want.status, rsp_payload.status);
            check_field("method", want.method, rsp_payload.method);
            check_field("version", want.version, rsp_payload.version);
            check_field("last", want.last, rsp_payload.last);
            if (want.kind == KIND_STATUS)
               status_seen[want.status]++;
         end
         results_checked++;
      end
   end

   // -------------------------------------------------------------------------
   // Result side: stall on a shifting pattern; a requested hold-off wins and
   // is counted down here, once per falling edge.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 48 == 0)
         stall_mode = $urandom_range(0, 3);
      if (rsp_hold_off > 0) begin
         rsp_hold_off--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= (stall_tick % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request byte; in gap mode insert an idle stretch between bursts.
   // Valid stays high after acceptance until the next falling edge decides.
   task automatic send_byte(input logic [7:0] b, input bit fresh, input bit eod);
      if (sender_gaps && burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, new_request: fresh, end_of_data: eod};
      do @(posedge clock); while (!req_ready);
      parse_request_byte(req_payload);
      bytes_sent++;
      if (burst_left > 0)
         burst_left--;
   endtask

   // Send a byte string: new_request on the first byte, end_of_data on the last
   task automatic send_request(input byte_queue_type q, input bit fresh, input bit eod_last);
      foreach (q[i])
         send_byte(q[i], fresh && i == 0, eod_last && i == q.size() - 1);
   endtask

   // Drop valid and hold until every owed result is in, then let the block
   // settle past its latency so bytes without results have drained too
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (parser_outputs_due.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_limit(input logic idx, input logic [10:0] value);
      wait_idle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_URI_LIMIT)
         uri_limit_now = value[7:0];
      else
         param_limit_now = value;
      limit_writes++;
   endtask

   function automatic byte_queue_type text_bytes(string s);
      byte_queue_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   // Line end plus blank line: CR LF CR LF, or LF LF
   function automatic byte_queue_type line_end_bytes(bit crlf);
      byte_queue_type q;
      if (crlf)
         q = {CH_CR, CH_LF, CH_CR, CH_LF};
      else
         q = {CH_LF, CH_LF};
      return q;
   endfunction

   // Any byte but space and '?', with line breaks now and then
   function automatic logic [7:0] random_uri_byte();
      logic [7:0] b;
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(0, 1) ? CH_LF : CH_CR;
      do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_QMARK);
      return b;
   endfunction

   function automatic byte_queue_type random_request_line();
      byte_queue_type q;
      q = text_bytes($urandom_range(0, 1) ? "PUT" : "GET");
      repeat ($urandom_range(1, 3)) q.push_back(CH_SPACE);
      repeat ($urandom_range(0, 10)) q.push_back(random_uri_byte());
      if ($urandom_range(0, 1)) begin
         q.push_back(CH_QMARK);
         repeat ($urandom_range(0, 10)) q.push_back(random_uri_byte());
      end
      repeat ($urandom_range(1, 2)) q.push_back(CH_SPACE);
      q = {q, text_bytes($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0")};
      if ($urandom_range(0, 2) == 0)
         q = {q, CH_CR, CH_LF, text_bytes("Host: h")};
      q = {q, line_end_bytes($urandom_range(0, 1))};
      return q;
   endfunction

   function automatic logic [10:0] pick_limit(int top);
      case ($urandom_range(0, 3))
         0:       return 11'd1;
         1:       return 11'($urandom_range(1, 16));
         2:       return 11'(top);
         default: return 11'($urandom_range(1, top));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Both methods, both versions, spacing, bad method, bad version, the zero
   // byte as the first byte, and the zero and all-ones bytes in the URI
   task automatic test_request_forms();
      byte_queue_type line;
      line = {text_bytes("GET /a?b HTTP/1.1"), line_end_bytes(1)};
      send_request(line, 1, 1);
      line = {text_bytes("PUT  /x?  HTTP/1.0"), line_end_bytes(0)};
      send_request(line, 1, 0);
      line = {text_bytes("POST /"), line_end_bytes(0)};
      send_request(line, 1, 0);
      line = {text_bytes("GET / HTTP/1.2"), line_end_bytes(1)};
      send_request(line, 1, 0);
      line = {8'h00, text_bytes("ET /"), line_end_bytes(0)};
      send_request(line, 1, 0);
      line = {text_bytes("GET /"), 8'h00, 8'hFF, text_bytes(" HTTP/1.0"), line_end_bytes(0)};
      send_request(line, 1, 1);
   endtask

   // Verdicts that wait for the blank line, data that runs out, and bytes
   // after the report
   task automatic test_held_verdict();
      byte_queue_type line;
      // Verdict known, no blank line yet: need-more, then report on it
      send_request(text_bytes("GET / HTTP/1.1"), 1, 1);
      line = {CH_CR, CH_LF, CH_CR, CH_LF};
      send_request(line, 0, 0);
      // Bytes after the report stay silent, even at end of data
      send_request(text_bytes("zz"), 0, 1);
      // Blank line inside the URI, data ends: URI bytes and bad version
      line = {text_bytes("GET /ab"), CH_LF, CH_LF};
      send_request(line, 1, 1);
      // No blank line at all: need-more twice, state kept between
      send_request(text_bytes("PUT /ab"), 1, 1);
      send_request(text_bytes("c"), 0, 1);
      // Blank line early inside the URI, verdict comes later
      line = {text_bytes("GET /"), CH_LF, CH_LF, text_bytes(" HTTP/1.1")};
      send_request(line, 1, 0);
      // Header line between request line and blank line
      line = {text_bytes("GET / HTTP/1.0"), CH_CR, CH_LF, text_bytes("Host: a"),
              line_end_bytes(1)};
      send_request(line, 1, 0);
   endtask

   // Block the result side long enough to fill the block and stall requests
   task automatic test_output_backpressure();
      byte_queue_type line;
      line = text_bytes("GET /");
      repeat (40) line.push_back(random_uri_byte());
      line = {line, text_bytes(" HTTP/1.1"), line_end_bytes(1)};
      wait_idle();
      sender_gaps  = 0;
      rsp_hold_off = 200;
      send_request(line, 1, 0);
      wait_idle();
   endtask

   // Limits of one, each hit and just passed, then limits of zero; restore
   // the reset limits afterwards
   task automatic test_length_limits();
      byte_queue_type line;
      write_limit(CSR_URI_LIMIT, 11'd1);
      write_limit(CSR_PARAM_LIMIT, 11'd1);
      line = {text_bytes("GET a?b HTTP/1.0"), line_end_bytes(0)};
      send_request(line, 1, 0);
      line = {text_bytes("GET ab?c HTTP/1.0"), line_end_bytes(0)};
      send_request(line, 1, 0);
      line = {text_bytes("GET a?bc HTTP/1.0"), line_end_bytes(1)};
      send_request(line, 1, 1);

      write_limit(CSR_URI_LIMIT, 11'd0);
      write_limit(CSR_PARAM_LIMIT, 11'd0);
      line = {text_bytes("GET a"), line_end_bytes(0)};
      send_request(line, 1, 0);
      line = {text_bytes("PUT ?a"), line_end_bytes(0)};
      send_request(line, 1, 0);

      write_limit(CSR_URI_LIMIT, URI_LIMIT_RESET);
      write_limit(CSR_PARAM_LIMIT, PARAM_LIMIT_RESET);
   endtask

   // Mostly well-formed requests with random content, plus corrupted,
   // truncated and unterminated ones, noise, and bytes after a report
   task automatic test_random_requests();
      byte_queue_type line;
      byte_queue_type head;
      byte_queue_type tail;
      int      start_count;
      int      cut;
      int      pick;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         if ($urandom_range(0, 39) == 0) begin
            write_limit(CSR_URI_LIMIT, pick_limit(255));
            write_limit(CSR_PARAM_LIMIT, pick_limit(1024));
         end
         // Pause now and then until everything owed has come back
         if ($urandom_range(0, 29) == 0)
            wait_idle();
         sender_gaps = ($urandom_range(0, 3) != 0);
         line = random_request_line();
         pick = $urandom_range(0, 15);
         if (pick < 10) begin
            send_request(line, 1, 1'($urandom_range(0, 1)));
         end else if (pick < 12) begin
            line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
            send_request(line, 1, 1'($urandom_range(0, 1)));
         end else if (pick == 12) begin
            cut  = $urandom_range(0, line.size() - 2);
            head = line[0:cut];
            tail = line[cut+1:$];
            send_request(head, 1, 1);
            send_request(tail, 0, 1'($urandom_range(0, 1)));
         end else if (pick == 13) begin
            repeat ($urandom_range(1, 8))
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end else if (pick == 14) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         end else begin
            // Drop the blank line's last two bytes
            head = line[0:line.size()-3];
            send_request(head, 1, 1);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      csr_write    = 1'b0;
      csr_index    = CSR_URI_LIMIT;
      csr_data     = '0;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b1;
      rsp_hold_off = 0;
      stall_mode   = 0;
      stall_tick   = 0;
      sender_gaps  = 0;
      burst_left   = 0;
      error_count  = 0;
      bytes_sent   = 0;
      results_checked = 0;
      limit_writes = 0;
      foreach (status_seen[i])
         status_seen[i] = 0;
      uri_limit_now   = URI_LIMIT_RESET;
      param_limit_now = PARAM_LIMIT_RESET;
      clear_parse_state();

      // Hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_request_forms();
      test_held_verdict();
      test_output_backpressure();
      test_length_limits();
      test_random_requests();

      // Drain: wait for every owed result, then past the block's latency
      wait_idle();

      $display("Parsed %0d request bytes across %0d limit writes; %0d results checked",
               bytes_sent, limit_writes, results_checked);
      $display("Reports: ok %0d, need-more %0d, bad method %0d, too long %0d, bad version %0d",
               status_seen[ST_OK], status_seen[ST_MORE], status_seen[ST_BAD_METHOD],
               status_seen[ST_TOO_LONG], status_seen[ST_BAD_VERSION]);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
